>>> design/phb_pkg.sv
// Shared types and constants for the path name hash bucket block.
// No dependencies; every other file of the block refers to it by scoped names.
package phb_pkg;

    localparam int unsigned HASH_W = 32;
    localparam int unsigned BYTE_W = 8;
    localparam int unsigned ROT_R  = 5;
    localparam logic [HASH_W-1:0] SEED_XOR = 32'd123456789;
    localparam logic [HASH_W-1:0] BUCKET_RESET = 32'd3;

    // back end sequencer
    typedef enum logic [1:0] {
        BK_IDLE,
        BK_DIV,
        BK_DONE
    } bk_state_t;

    // queue status seen by the front and back ends
    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

endpackage

>>> design/phb_front.sv
// Front end: accepts name bytes, keeps the running rotate-xor hash and
// pushes the finished hash of each name into the queue. Uses phb_pkg.
module phb_front (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [phb_pkg::HASH_W-1:0]    dir_offset,
    input  logic [phb_pkg::BYTE_W-1:0]    name_byte,
    input  logic                          has_byte,
    input  logic                          first,
    input  logic                          last,
    input  phb_pkg::q_stat_t              q_stat,
    output logic                          push,
    output logic [phb_pkg::HASH_W-1:0]    push_data
);

    logic [phb_pkg::HASH_W-1:0] hash_reg;
    logic [phb_pkg::HASH_W-1:0] hash_next;
    logic [phb_pkg::HASH_W-1:0] seeded;
    logic                       accept;

    assign s_tready = !q_stat.full;
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        seeded = first ? (dir_offset ^ phb_pkg::SEED_XOR) : hash_reg;
        if (has_byte) begin
            hash_next = {seeded[phb_pkg::ROT_R-1:0], seeded[phb_pkg::HASH_W-1:phb_pkg::ROT_R]}
                        ^ {{(phb_pkg::HASH_W-phb_pkg::BYTE_W){1'b0}}, name_byte};
        end else begin
            hash_next = seeded;
        end
    end

    assign push      = accept && last;
    assign push_data = hash_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hash_reg <= '0;
        end else if (accept) begin
            hash_reg <= hash_next;
        end
    end

endmodule

>>> design/phb_queue.sv
// Short hash queue between the front and back ends.
// Register array with read and write pointers; uses phb_pkg.
module phb_queue #(
    parameter int unsigned DEPTH = 4
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          push,
    input  logic [phb_pkg::HASH_W-1:0]    push_data,
    input  logic                          pop,
    output logic [phb_pkg::HASH_W-1:0]    pop_data,
    output phb_pkg::q_stat_t              q_stat
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    logic [phb_pkg::HASH_W-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0]           wr_ptr_reg;
    logic [PTR_W-1:0]           rd_ptr_reg;
    logic [CNT_W-1:0]           count_reg;
    logic [CNT_W-1:0]           count_next;

    assign q_stat.full  = (count_reg == FULL_CNT);
    assign q_stat.empty = (count_reg == '0);
    assign pop_data     = mem_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        case ({push, pop})
            2'b10:   count_next = count_reg + CNT_W'(1);
            2'b01:   count_next = count_reg - CNT_W'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

`ifndef SYNTH
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push && !pop |-> !q_stat.full)
        else $error("queue written while full");
    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> !q_stat.empty)
        else $error("queue read while empty");
`endif

endmodule

>>> design/phb_back.sv
// Back end: takes hashes from the queue, reduces each modulo the bucket count
// one quotient bit per cycle, and holds the result in the output register.
// Uses phb_pkg.
module phb_back (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [phb_pkg::HASH_W-1:0]    bucket_count,
    input  phb_pkg::q_stat_t              q_stat,
    input  logic [phb_pkg::HASH_W-1:0]    pop_data,
    output logic                          pop,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [phb_pkg::HASH_W-1:0]    hash_out,
    output logic [phb_pkg::HASH_W-1:0]    bucket_index
);

    localparam int unsigned W     = phb_pkg::HASH_W;
    localparam int unsigned CNT_W = $clog2(W);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(W - 1);

    phb_pkg::bk_state_t state_reg, state_next;

    logic [W-1:0]     hash_reg;
    logic [W-1:0]     shift_reg, shift_next;
    logic [W:0]       rem_reg, rem_next;
    logic [CNT_W-1:0] step_reg, step_next;
    logic [W:0]       trial;
    logic [W:0]       divisor;

    logic             m_valid_reg;
    logic [W-1:0]     m_hash_reg;
    logic [W-1:0]     m_bucket_reg;
    logic             out_load;
    logic             out_free;

    assign divisor  = {1'b0, bucket_count};
    assign trial    = {rem_reg[W-1:0], shift_reg[W-1]};
    assign out_free = !m_valid_reg || m_tready;

    always_comb begin
        state_next = state_reg;
        shift_next = shift_reg;
        rem_next   = rem_reg;
        step_next  = step_reg;
        pop        = 1'b0;
        out_load   = 1'b0;
        case (state_reg)
            phb_pkg::BK_IDLE: begin
                if (!q_stat.empty) begin
                    pop        = 1'b1;
                    shift_next = pop_data;
                    rem_next   = '0;
                    step_next  = '0;
                    state_next = phb_pkg::BK_DIV;
                end
            end
            phb_pkg::BK_DIV: begin
                rem_next   = (trial >= divisor) ? trial - divisor : trial;
                shift_next = {shift_reg[W-2:0], 1'b0};
                step_next  = step_reg + CNT_W'(1);
                if (step_reg == LAST_STEP) begin
                    state_next = phb_pkg::BK_DONE;
                end
            end
            phb_pkg::BK_DONE: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    state_next = phb_pkg::BK_IDLE;
                end
            end
            default: state_next = phb_pkg::BK_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= phb_pkg::BK_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        shift_reg <= shift_next;
        rem_reg   <= rem_next;
        step_reg  <= step_next;
        if (pop) begin
            hash_reg <= pop_data;
        end
        if (out_load) begin
            m_hash_reg   <= hash_reg;
            // zero divisor gives bucket zero
            m_bucket_reg <= (bucket_count == '0) ? '0 : rem_reg[W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    assign m_tvalid     = m_valid_reg;
    assign hash_out     = m_hash_reg;
    assign bucket_index = m_bucket_reg;

`ifndef SYNTH
    a_rem_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != phb_pkg::BK_IDLE) && (bucket_count != '0) |-> rem_reg < divisor)
        else $error("partial remainder not below bucket count");
    a_pop_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> state_reg == phb_pkg::BK_IDLE)
        else $error("queue read outside idle");
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !m_tready |=> m_valid_reg && $stable(m_hash_reg))
        else $error("pending result overwritten");
`endif

endmodule

>>> design/path_name_hash_bucket.sv
// Top level of the path name hash bucket block: bucket count register and
// the front end, queue and back end. Uses phb_pkg, phb_front, phb_queue, phb_back.
//
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+------------------------------------------
//  s_       | in        | s_tvalid/s_tready  | s_tdata, s_tuser, s_tlast (one name byte)
//  m_       | out       | m_tvalid/m_tready  | m_tdata (hash and bucket index)
//  cfg_     | in        | cfg_wr_en          | cfg_wr_data (bucket count)
//
// The front end takes one name byte every cycle while the queue has room.
// Each result passes through the back end in order: it is taken from the queue,
// goes through 32 steps of the restoring divider, then is loaded into the output register;
// no new hash is taken from the queue before that load, which waits while m_ is stalled.
// Reset is synchronous on aresetn low; bucket count resets to 3.
// A stalled m_ side fills the queue and then drops s_tready.
module path_name_hash_bucket #(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // dir_offset[31:0], name_byte[39:32]
    input  logic [1:0]  s_tuser,   // has_byte[0], first[1]
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // hash[31:0], bucket_index[63:32]
    input  logic        cfg_wr_en,
    input  logic [31:0] cfg_wr_data
);

    logic [phb_pkg::HASH_W-1:0] bucket_count_reg;
    logic [phb_pkg::HASH_W-1:0] push_data;
    logic [phb_pkg::HASH_W-1:0] pop_data;
    logic [phb_pkg::HASH_W-1:0] hash_out;
    logic [phb_pkg::HASH_W-1:0] bucket_index;
    logic                       push;
    logic                       pop;
    phb_pkg::q_stat_t           q_stat;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bucket_count_reg <= phb_pkg::BUCKET_RESET;
        end else if (cfg_wr_en) begin
            bucket_count_reg <= cfg_wr_data;
        end
    end

    phb_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .dir_offset    (s_tdata[31:0]),
        .name_byte     (s_tdata[39:32]),
        .has_byte      (s_tuser[0]),
        .first         (s_tuser[1]),
        .last          (s_tlast),
        .q_stat        (q_stat),
        .push          (push),
        .push_data     (push_data)
    );

    phb_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .q_stat    (q_stat)
    );

    phb_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .bucket_count (bucket_count_reg),
        .q_stat       (q_stat),
        .pop_data     (pop_data),
        .pop          (pop),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .hash_out     (hash_out),
        .bucket_index (bucket_index)
    );

    assign m_tdata = {bucket_index, hash_out};

endmodule
